// File: hdl/dgi_pkg.sv
// Package for the determinant group index: sizes, command and status codes.
// No dependencies; used by determinant_group_index.
package dgi_pkg;
  localparam int MaxDets = 1024;
  localparam int IdW = $clog2(MaxDets);
  localparam int CntW = IdW + 1;
  localparam int StrW = 64;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0, FN_BUILD = 3'd1, FN_APTR = 3'd2, FN_AENT = 3'd3,
    FN_BPTR = 3'd4, FN_BENT = 3'd5, FN_UNIQ = 3'd6, FN_CLEAR = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_RANGE = 2'd2, ST_UNBUILT = 2'd3
  } status_t;
endpackage

// File: hdl/dgi_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// No dependencies; registered read data.
module dgi_ram #(
  parameter int W = 8,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/determinant_group_index.sv
// Determinant group index, top level: command sequencer over the RAMs.
// Depends on dgi_pkg and dgi_ram.
//
// Usage: drive in_func and the payload and raise start. The command is
// transferred at the first rising edge with start high and busy low, and busy
// then stays high until the result is out. Exactly one result transfer
// follows, marked by out_valid for one cycle. The receiver cannot stall, so
// the result is never held. A new command can be transferred at the edge that
// ends the result cycle, so the period of a command equals its latency.
// Clear, an append to a full store and any refused read go straight to the
// result; pointer and unique string reads make a single RAM read, and grouped
// entry reads read the list entry, then the determinant's ids, then its
// strings. An append scans each dictionary one entry a cycle through the RAM
// read port. A build zeroes, counts, prefix-sums and scatters each side in
// turn. The single read port of each memory sets the rate. Reset (rst_n low,
// synchronous) clears the totals and the built flag; the memories keep their
// contents and are only read below the totals, so there is no clearing pass.
// Clear likewise only zeroes the totals and the flag.
module determinant_group_index
  import dgi_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      in_func,
  input  logic [StrW-1:0] in_alpha_string,
  input  logic [StrW-1:0] in_beta_string,
  input  logic [CntW-1:0] in_index,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [IdW-1:0]  out_det_index,
  output logic [IdW-1:0]  out_alpha_sid,
  output logic [IdW-1:0]  out_beta_id,
  output logic [CntW-1:0] out_pointer_value,
  output logic [StrW-1:0] out_alpha_string_out,
  output logic [StrW-1:0] out_beta_string_out,
  output logic [CntW-1:0] out_alpha_count,
  output logic [CntW-1:0] out_beta_count,
  output logic [CntW-1:0] out_det_count
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SCAN = 13'b0000000000010,  // dictionary scan, one entry a cycle
    S_APWR = 13'b0000000000100,  // write the determinant's ids
    S_ZERO = 13'b0000000001000,  // clear the count RAM over the id range
    S_WA   = 13'b0000000010000,  // walk: read the determinant's ids
    S_WB   = 13'b0000000100000,  // walk: read the count of its id
    S_WC   = 13'b0000001000000,  // walk: bump the count, scatter if asked
    S_PFX  = 13'b0000010000000,  // prefix sums into the pointer RAM
    S_RD1  = 13'b0000100000000,
    S_RD2  = 13'b0001000000000,
    S_RD3  = 13'b0010000000000,
    S_RD4  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t          state_r;
  func_t           func_r;
  logic [StrW-1:0] as_r, bs_r;
  logic [CntW-1:0] idx_r;
  logic [CntW-1:0] det_total_r, alpha_total_r, beta_total_r;
  logic            built_r;
  logic            side_r;           // 0 alpha side, 1 beta side
  logic            scat_r;           // walk scatters instead of counting
  logic            pend_r;           // a read issued last cycle is on the RAM output
  logic [CntW-1:0] i_r;              // walk counter
  logic [CntW-1:0] acc_r;            // prefix accumulator
  logic [IdW-1:0]  key_r;            // id whose count is being updated
  logic [IdW-1:0]  aid_r, bid_r;

  // Result registers.
  logic            ov_r;
  status_t         st_r;
  logic [IdW-1:0]  od_r, oa_r, ob_r;
  logic [CntW-1:0] op_r;
  logic [StrW-1:0] osa_r, osb_r;

  // Memory controls.
  logic            ua_we, ub_we, dai_we, dbi_we, ap_we, bp_we, cnt_we;
  logic            agd_we, bgd_we;
  logic [IdW-1:0]  cnt_wa, cnt_ra;
  logic [CntW-1:0] cnt_wd;
  logic [IdW-1:0]  ua_ra, ub_ra, dai_ra;
  logic [StrW-1:0] ua_q, ub_q;
  logic [IdW-1:0]  dai_q, dbi_q, agd_q, bgd_q;
  logic [CntW-1:0] ap_q, bp_q, cnt_q;

  dgi_ram #(.W(StrW), .AW(IdW)) u_ua (.clk, .we(ua_we),
    .waddr(alpha_total_r[IdW-1:0]), .wdata(as_r), .raddr(ua_ra), .rdata(ua_q));
  dgi_ram #(.W(StrW), .AW(IdW)) u_ub (.clk, .we(ub_we),
    .waddr(beta_total_r[IdW-1:0]), .wdata(bs_r), .raddr(ub_ra), .rdata(ub_q));
  dgi_ram #(.W(IdW), .AW(IdW)) u_dai (.clk, .we(dai_we),
    .waddr(det_total_r[IdW-1:0]), .wdata(aid_r), .raddr(dai_ra), .rdata(dai_q));
  dgi_ram #(.W(IdW), .AW(IdW)) u_dbi (.clk, .we(dbi_we),
    .waddr(det_total_r[IdW-1:0]), .wdata(bid_r), .raddr(dai_ra), .rdata(dbi_q));
  dgi_ram #(.W(CntW), .AW(CntW)) u_ap (.clk, .we(ap_we), .waddr(i_r),
    .wdata(acc_r), .raddr(idx_r), .rdata(ap_q));
  dgi_ram #(.W(CntW), .AW(CntW)) u_bp (.clk, .we(bp_we), .waddr(i_r),
    .wdata(acc_r), .raddr(idx_r), .rdata(bp_q));
  dgi_ram #(.W(CntW), .AW(IdW)) u_cnt (.clk, .we(cnt_we), .waddr(cnt_wa),
    .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_q));
  dgi_ram #(.W(IdW), .AW(IdW)) u_agd (.clk, .we(agd_we), .waddr(cnt_q[IdW-1:0]),
    .wdata(i_r[IdW-1:0]), .raddr(idx_r[IdW-1:0]), .rdata(agd_q));
  dgi_ram #(.W(IdW), .AW(IdW)) u_bgd (.clk, .we(bgd_we), .waddr(cnt_q[IdW-1:0]),
    .wdata(i_r[IdW-1:0]), .raddr(idx_r[IdW-1:0]), .rdata(bgd_q));

  func_t           in_cmd;
  status_t         rd_status;    // status of a read command at its transfer
  logic [CntW-1:0] nid;          // id count of the current side
  logic [IdW-1:0]  key_q;        // id of the determinant just read
  logic [IdW-1:0]  ent_d;        // determinant read from a grouped list
  logic [StrW-1:0] scan_q, scan_s;
  logic            scan_hit, scan_ins;
  logic [IdW-1:0]  scan_id;
  logic            full;

  assign in_cmd = func_t'(in_func);
  assign nid    = side_r ? beta_total_r : alpha_total_r;
  assign key_q  = side_r ? dbi_q : dai_q;
  assign ent_d  = (func_r == FN_AENT) ? agd_q : bgd_q;
  assign scan_q = side_r ? ub_q : ua_q;
  assign scan_s = side_r ? bs_r : as_r;
  assign full   = det_total_r == CntW'(MaxDets);
  // The entry read last cycle sits at i_r - 1. A miss once every entry has
  // been compared inserts the string at the end of the dictionary.
  assign scan_hit = pend_r && (scan_q == scan_s);
  assign scan_ins = !scan_hit && (i_r == nid);
  assign scan_id  = scan_hit ? (i_r[IdW-1:0] - IdW'(1)) : i_r[IdW-1:0];

  always_comb begin
    rd_status = ST_OK;
    if (in_cmd == FN_UNIQ) begin
      if (in_index >= alpha_total_r && in_index >= beta_total_r) rd_status = ST_RANGE;
    end else if (!built_r) begin
      rd_status = ST_UNBUILT;
    end else if ((in_cmd == FN_APTR && in_index > alpha_total_r) ||
                 (in_cmd == FN_BPTR && in_index > beta_total_r) ||
                 ((in_cmd == FN_AENT || in_cmd == FN_BENT) &&
                  in_index >= det_total_r)) begin
      rd_status = ST_RANGE;
    end
  end

  always_comb begin
    ua_we = 1'b0; ub_we = 1'b0; dai_we = 1'b0; dbi_we = 1'b0;
    ap_we = 1'b0; bp_we = 1'b0; cnt_we = 1'b0;
    agd_we = 1'b0; bgd_we = 1'b0;
    cnt_wa = key_r;
    cnt_wd = cnt_q + CntW'(1);
    cnt_ra = key_q;
    ua_ra = i_r[IdW-1:0];
    ub_ra = i_r[IdW-1:0];
    dai_ra = i_r[IdW-1:0];
    unique case (state_r)
      S_SCAN: begin
        if (scan_ins) begin
          if (side_r) ub_we = 1'b1;
          else ua_we = 1'b1;
        end
      end
      S_APWR: begin
        dai_we = 1'b1;
        dbi_we = 1'b1;
      end
      S_ZERO: begin
        if (i_r != nid) begin
          cnt_we = 1'b1;
          cnt_wa = i_r[IdW-1:0];
          cnt_wd = '0;
        end
      end
      S_WC: begin
        // Count: bump the id's count. Scatter: the count RAM holds the next
        // free list position of the id, so place the determinant there.
        cnt_we = 1'b1;
        if (scat_r) begin
          if (side_r) bgd_we = 1'b1;
          else agd_we = 1'b1;
        end
      end
      S_PFX: begin
        cnt_ra = i_r[IdW-1:0];
        // The pointer of id i_r is the running sum; the last pointer, at the
        // id count, equals the determinant count.
        if (pend_r || i_r == nid) begin
          if (side_r) bp_we = 1'b1;
          else ap_we = 1'b1;
        end
        if (pend_r) begin
          cnt_we = 1'b1;
          cnt_wa = i_r[IdW-1:0];
          cnt_wd = acc_r;           // the count becomes the fill position
        end
      end
      S_RD1: begin
        ua_ra = idx_r[IdW-1:0];
        ub_ra = idx_r[IdW-1:0];
      end
      S_RD2: dai_ra = ent_d;
      S_RD3: begin
        ua_ra = dai_q;
        ub_ra = dbi_q;
      end
      S_IDLE, S_WA, S_WB, S_RD4, S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ov_r <= rst_n && (state_r == S_DONE);
    if (!rst_n) begin
      state_r <= S_IDLE;
      det_total_r <= '0;
      alpha_total_r <= '0;
      beta_total_r <= '0;
      built_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r <= in_cmd;
            as_r <= in_alpha_string;
            bs_r <= in_beta_string;
            idx_r <= in_index;
            i_r <= '0;
            side_r <= 1'b0;
            scat_r <= 1'b0;
            acc_r <= '0;
            pend_r <= 1'b0;
            od_r <= '0; oa_r <= '0; ob_r <= '0; op_r <= '0;
            osa_r <= '0; osb_r <= '0;
            unique case (in_cmd) inside
              FN_APPEND: begin
                st_r <= full ? ST_FULL : ST_OK;
                state_r <= full ? S_DONE : S_SCAN;
              end
              FN_BUILD: begin
                st_r <= ST_OK;
                state_r <= S_ZERO;
              end
              FN_APTR, FN_BPTR, FN_AENT, FN_BENT, FN_UNIQ: begin
                st_r <= rd_status;
                state_r <= (rd_status == ST_OK) ? S_RD1 : S_DONE;
              end
              FN_CLEAR: begin
                det_total_r <= '0;
                alpha_total_r <= '0;
                beta_total_r <= '0;
                built_r <= 1'b0;
                st_r <= ST_OK;
                state_r <= S_DONE;
              end
              default: begin
                st_r <= ST_OK;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_hit || scan_ins) begin
            pend_r <= 1'b0;
            i_r <= '0;
            if (side_r) begin
              bid_r <= scan_id;
              if (scan_ins) beta_total_r <= beta_total_r + CntW'(1);
              state_r <= S_APWR;
            end else begin
              aid_r <= scan_id;
              if (scan_ins) alpha_total_r <= alpha_total_r + CntW'(1);
              side_r <= 1'b1;
            end
          end else begin
            i_r <= i_r + CntW'(1);
            pend_r <= 1'b1;
          end
        end
        S_APWR: begin
          od_r <= det_total_r[IdW-1:0];
          oa_r <= aid_r;
          ob_r <= bid_r;
          osa_r <= as_r;
          osb_r <= bs_r;
          det_total_r <= det_total_r + CntW'(1);
          built_r <= 1'b0;
          state_r <= S_DONE;
        end
        S_ZERO: begin
          if (i_r == nid) begin
            i_r <= '0;
            state_r <= S_WA;
          end else begin
            i_r <= i_r + CntW'(1);
          end
        end
        // Each determinant passes through S_WA, S_WB and S_WC in turn, so the count read of the next
        // one always comes after the write of this one.
        S_WA: begin
          if (i_r == det_total_r) begin
            i_r <= '0;
            if (!scat_r) begin
              acc_r <= '0;
              pend_r <= 1'b0;
              state_r <= S_PFX;
            end else if (side_r) begin
              built_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              side_r <= 1'b1;
              scat_r <= 1'b0;
              state_r <= S_ZERO;
            end
          end else begin
            state_r <= S_WB;
          end
        end
        S_WB: begin
          key_r <= key_q;
          state_r <= S_WC;
        end
        S_WC: begin
          i_r <= i_r + CntW'(1);
          state_r <= S_WA;
        end
        S_PFX: begin
          if (pend_r) begin
            acc_r <= acc_r + cnt_q;
            i_r <= i_r + CntW'(1);
            pend_r <= 1'b0;
          end else if (i_r == nid) begin
            i_r <= '0;
            scat_r <= 1'b1;
            state_r <= S_WA;
          end else begin
            pend_r <= 1'b1;
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          if (func_r == FN_APTR) begin
            op_r <= ap_q;
            state_r <= S_DONE;
          end else if (func_r == FN_BPTR) begin
            op_r <= bp_q;
            state_r <= S_DONE;
          end else if (func_r == FN_UNIQ) begin
            // Only the sides that hold this id return it.
            if (idx_r < alpha_total_r) begin
              oa_r <= idx_r[IdW-1:0];
              osa_r <= ua_q;
            end
            if (idx_r < beta_total_r) begin
              ob_r <= idx_r[IdW-1:0];
              osb_r <= ub_q;
            end
            state_r <= S_DONE;
          end else begin
            od_r <= ent_d;
            state_r <= S_RD3;
          end
        end
        S_RD3: begin
          oa_r <= dai_q;
          ob_r <= dbi_q;
          state_r <= S_RD4;
        end
        S_RD4: begin
          osa_r <= ua_q;
          osb_r <= ub_q;
          state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_det_index = od_r;
  assign out_alpha_sid = oa_r;
  assign out_beta_id = ob_r;
  assign out_pointer_value = op_r;
  assign out_alpha_string_out = osa_r;
  assign out_beta_string_out = osb_r;
  assign out_alpha_count = alpha_total_r;
  assign out_beta_count = beta_total_r;
  assign out_det_count = det_total_r;
endmodule
